// ----- rtl/mesi_lc_pkg.sv -----
package mesi_lc_pkg;

  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_STORE = 3'd1;
  localparam logic [2:0] CMD_GETS  = 3'd2;
  localparam logic [2:0] CMD_GETM  = 3'd3;
  localparam logic [2:0] CMD_DATA  = 3'd4;

  localparam logic [2:0] ST_I  = 3'd0;
  localparam logic [2:0] ST_S  = 3'd1;
  localparam logic [2:0] ST_E  = 3'd2;
  localparam logic [2:0] ST_M  = 3'd3;
  localparam logic [2:0] ST_IM = 3'd4;
  localparam logic [2:0] ST_IS = 3'd5;
  localparam logic [2:0] ST_SM = 3'd6;

  localparam logic [1:0] BUS_NONE = 2'd0;
  localparam logic [1:0] BUS_GETS = 2'd1;
  localparam logic [1:0] BUS_GETM = 2'd2;

  localparam logic [1:0] DRV_LEAVE    = 2'd0;
  localparam logic [1:0] DRV_ASSERT   = 2'd1;
  localparam logic [1:0] DRV_DEASSERT = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRANSIENT = 2'd1;
  localparam logic [1:0] ERR_UNEXPECT  = 2'd2;

  localparam int unsigned LINE_IDX_W = 10;
  localparam int unsigned NODE_W     = 4;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [LINE_IDX_W-1:0] line_index;
    logic [NODE_W-1:0]     requester_id;
    logic                  shared_in;
  } in_t;

  typedef struct packed {
    logic [1:0]        bus_request;
    logic              data_to_proc;
    logic              data_on_bus;
    logic [NODE_W-1:0] data_dest;
    logic [1:0]        shared_drive;
    logic              miss;
    logic              silent_upgrade;
    logic [1:0]        error;
    logic [2:0]        new_state;
  } out_t;

endpackage

// ----- rtl/mesi_snoop_line_controller_core.sv -----
// Channel | Dir | Handshake                 | Payload
// input   | in  | in_valid_i / in_ready_o   | mesi_lc_pkg::in_t (cmd, line, requester, shared)
// output  | out | out_valid_o / out_ready_i | mesi_lc_pkg::out_t (one result per transaction)
//
// Sustains one transaction per cycle unless the output stalls; a transaction passes the A, B and output registers.
// The rate is set by the line state memory: one read and one write port, with the
// written-back state forwarded to a following transaction on the same line.
// After reset a clearing pass sets every line to I; in_ready_o stays low.
// A stalled output holds the pipeline; empty stages still take new transactions.
module mesi_snoop_line_controller_core #(
  parameter int unsigned LINES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mesi_lc_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mesi_lc_pkg::out_t  out_data_o
);
  import mesi_lc_pkg::*;

  localparam int unsigned IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam bit          MOD_EN = (LINES < 1024);
  localparam int unsigned RSH    = 20;
  localparam int unsigned RECIP  = MOD_EN ? ((32'd1 << RSH) / LINES) : 0;
  localparam logic [19:0] LINES_W = MOD_EN ? 20'(LINES) : 20'd0;

  logic [2:0] mem [LINES];

  logic             clr_q, clr_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             a_v_q, a_v_d;
  logic             b_v_q, b_v_d;
  logic             out_v_q, out_v_d;
  logic             fwd_hit_q, fwd_hit_d;

  in_t              a_item_q;
  logic [9:0]       a_quot_q;
  logic [2:0]       b_cmd_q;
  logic [NODE_W-1:0] b_req_q;
  logic             b_shr_q;
  logic [IDX_W-1:0] b_idx_q;
  logic [2:0]       fwd_st_q;
  logic [2:0]       rd_q;
  out_t             out_q;

  logic             en_out, en_b, en_a, b_go, a_go, in_go;
  logic [30:0]      prod;
  logic [19:0]      rem, rem_fix;
  logic [IDX_W-1:0] a_idx;
  logic [2:0]       b_state;
  out_t             xfer_res;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [2:0]       mem_wdata;

  assign en_out = !out_v_q || out_ready_i;
  assign b_go   = b_v_q && en_out;
  assign en_b   = !b_v_q || en_out;
  assign a_go   = a_v_q && en_b;
  assign en_a   = !a_v_q || en_b;
  assign in_ready_o = en_a && !clr_q;
  assign in_go  = in_valid_i && in_ready_o;

  assign prod    = 31'(in_data_i.line_index) * 31'(RECIP);
  assign rem     = 20'(a_item_q.line_index) - (20'(a_quot_q) * LINES_W);
  assign rem_fix = (rem >= LINES_W) ? (rem - LINES_W) : rem;
  assign a_idx   = MOD_EN ? IDX_W'(rem_fix) : IDX_W'(a_item_q.line_index);

  assign b_state = fwd_hit_q ? fwd_st_q : rd_q;

  mesi_lc_xfer u_xfer (
    .cmd_i          (b_cmd_q),
    .requester_id_i (b_req_q),
    .shared_in_i    (b_shr_q),
    .state_i        (b_state),
    .result_o       (xfer_res)
  );

  assign mem_we    = clr_q || b_go;
  assign mem_waddr = clr_q ? clr_cnt_q : b_idx_q;
  assign mem_wdata = clr_q ? ST_I : xfer_res.new_state;

  always_comb begin
    clr_cnt_d = clr_cnt_q + 1'b1;
    clr_d     = clr_q && (clr_cnt_q != IDX_W'(LINES - 1));
    a_v_d     = en_a ? in_go : a_v_q;
    b_v_d     = en_b ? a_v_q : b_v_q;
    out_v_d   = en_out ? b_v_q : out_v_q;
    fwd_hit_d = a_go ? (b_go && (b_idx_q == a_idx)) : fwd_hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      out_v_q   <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      if (clr_q) clr_cnt_q <= clr_cnt_d;
      a_v_q     <= a_v_d;
      b_v_q     <= b_v_d;
      out_v_q   <= out_v_d;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      a_item_q <= in_data_i;
      a_quot_q <= prod[RSH+9:RSH];
    end
    if (a_go) begin
      b_cmd_q  <= a_item_q.cmd;
      b_req_q  <= a_item_q.requester_id;
      b_shr_q  <= a_item_q.shared_in;
      b_idx_q  <= a_idx;
      fwd_st_q <= xfer_res.new_state;
    end
    if (b_go) out_q <= xfer_res;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (a_go) rd_q <= mem[a_idx];
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/mesi_lc_xfer.sv -----
module mesi_lc_xfer (
  input  logic [2:0]                  cmd_i,
  input  logic [mesi_lc_pkg::NODE_W-1:0] requester_id_i,
  input  logic                        shared_in_i,
  input  logic [2:0]                  state_i,
  output mesi_lc_pkg::out_t           result_o
);
  import mesi_lc_pkg::*;

  logic [1:0] busreq;
  logic       toproc;
  logic       onbus;
  logic [1:0] drive;
  logic       miss;
  logic       silent;
  logic [1:0] err;
  logic [2:0] ns;
  logic       store;

  always_comb begin
    busreq = BUS_NONE;
    toproc = 1'b0;
    onbus  = 1'b0;
    drive  = DRV_LEAVE;
    miss   = 1'b0;
    silent = 1'b0;
    err    = ERR_NONE;
    ns     = state_i;
    store  = (cmd_i == CMD_STORE);
    if (cmd_i inside {CMD_LOAD, CMD_STORE}) begin
      case (state_i)
        ST_I: begin
          busreq = store ? BUS_GETM : BUS_GETS;
          ns     = store ? ST_IM : ST_IS;
          miss   = 1'b1;
        end
        ST_S: begin
          if (store) begin
            busreq = BUS_GETM;
            ns     = ST_SM;
            miss   = 1'b1;
          end else begin
            toproc = 1'b1;
          end
        end
        ST_E: begin
          toproc = 1'b1;
          if (store) begin
            ns     = ST_M;
            silent = 1'b1;
          end
        end
        ST_M: toproc = 1'b1;
        default: err = ERR_TRANSIENT;
      endcase
    end else if (cmd_i inside {CMD_GETS, CMD_GETM, CMD_DATA}) begin
      case (state_i)
        ST_I: ;
        ST_S: begin
          if (cmd_i == CMD_GETS) drive = DRV_ASSERT;
          else if (cmd_i == CMD_GETM) ns = ST_I;
          else err = ERR_UNEXPECT;
        end
        ST_E, ST_M: begin
          if (cmd_i == CMD_GETS) begin
            onbus = 1'b1;
            drive = DRV_ASSERT;
            ns    = ST_S;
          end else if (cmd_i == CMD_GETM) begin
            onbus = 1'b1;
            ns    = ST_I;
          end else if (state_i == ST_M) begin
            err = ERR_UNEXPECT;
          end
        end
        ST_IM: begin
          if (cmd_i == CMD_DATA) begin
            toproc = 1'b1;
            drive  = DRV_DEASSERT;
            ns     = ST_M;
          end
        end
        ST_IS: begin
          if (cmd_i == CMD_DATA) begin
            toproc = 1'b1;
            if (shared_in_i) begin
              ns = ST_S;
            end else begin
              ns    = ST_E;
              drive = DRV_DEASSERT;
            end
          end
        end
        ST_SM: begin
          if (cmd_i == CMD_GETS) begin
            drive = DRV_ASSERT;
          end else if (cmd_i == CMD_DATA) begin
            toproc = 1'b1;
            ns     = ST_M;
          end
        end
        default: err = ERR_UNEXPECT;
      endcase
    end else begin
      err = ERR_UNEXPECT;
    end
    if (err != ERR_NONE) ns = state_i;
  end

  assign result_o.bus_request    = busreq;
  assign result_o.data_to_proc   = toproc;
  assign result_o.data_on_bus    = onbus;
  assign result_o.data_dest      = onbus ? requester_id_i : '0;
  assign result_o.shared_drive   = drive;
  assign result_o.miss           = miss;
  assign result_o.silent_upgrade = silent;
  assign result_o.error          = err;
  assign result_o.new_state      = ns;

endmodule

// ----- rtl/mesi_lc_checker.sv -----
module mesi_lc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input mesi_lc_pkg::out_t out_data_o
);
  import mesi_lc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("transaction taken during clearing pass");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error != ERR_NONE |->
      out_data_o.bus_request == BUS_NONE && !out_data_o.data_on_bus && !out_data_o.miss)
    else $error("error result drives the bus");

  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.silent_upgrade |->
      out_data_o.new_state == ST_M && out_data_o.data_to_proc
      && out_data_o.bus_request == BUS_NONE)
    else $error("silent upgrade without move to M");

  a_miss_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.miss |-> out_data_o.bus_request != BUS_NONE)
    else $error("miss without bus request");

endmodule

bind mesi_snoop_line_controller_core mesi_lc_checker u_mesi_lc_checker (.*);

// ----- tb/tb.sv -----
module tb;
  import mesi_lc_pkg::*;

  localparam int unsigned LINES       = 1024;
  localparam int unsigned N_RANDOM    = 1220;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned CYCLE_LIMIT = 500000;

  localparam logic [2:0] CMD_BAD_FIRST = CMD_DATA + 3'd1;
  localparam logic [2:0] CMD_BAD_LAST  = '1;

  typedef struct {
    in_t         item;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic in_valid   = 1'b0;
  logic in_ready_o;
  in_t  in_data    = '0;
  logic out_valid_o;
  logic out_ready  = 1'b0;
  out_t out_data_o;

  pending_t    pending_q[$];
  out_t        expected_q[$];
  logic [2:0]  line_tbl[LINES];
  int unsigned n_in, n_out, total, err_cnt, cycles;
  int unsigned tx_wait, rx_wait, hold_cnt;
  bit          rx_busy, hold_off, hold_done;

  mesi_snoop_line_controller_core #(
    .LINES(LINES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  function automatic out_t predict_line_result(input in_t it);
    out_t        r;
    logic [2:0]  st, ns;
    bit          is_store;
    int unsigned idx;
    r = '0;
    idx = it.line_index % LINES;
    st = line_tbl[idx];
    ns = st;
    if (it.cmd == CMD_LOAD || it.cmd == CMD_STORE) begin
      is_store = (it.cmd == CMD_STORE);
      case (st)
        ST_I: begin
          r.bus_request = is_store ? BUS_GETM : BUS_GETS;
          ns = is_store ? ST_IM : ST_IS;
          r.miss = 1'b1;
        end
        ST_S: begin
          if (is_store) begin
            r.bus_request = BUS_GETM;
            ns = ST_SM;
            r.miss = 1'b1;
          end else begin
            r.data_to_proc = 1'b1;
          end
        end
        ST_E: begin
          r.data_to_proc = 1'b1;
          if (is_store) begin
            ns = ST_M;
            r.silent_upgrade = 1'b1;
          end
        end
        ST_M: r.data_to_proc = 1'b1;
        default: r.error = ERR_TRANSIENT;
      endcase
    end else if (it.cmd == CMD_GETS || it.cmd == CMD_GETM || it.cmd == CMD_DATA) begin
      case (st)
        ST_I: ;
        ST_S: begin
          case (it.cmd)
            CMD_GETS: r.shared_drive = DRV_ASSERT;
            CMD_GETM: ns = ST_I;
            default:  r.error = ERR_UNEXPECT;
          endcase
        end
        ST_E, ST_M: begin
          case (it.cmd)
            CMD_GETS: begin
              r.data_on_bus = 1'b1;
              r.shared_drive = DRV_ASSERT;
              ns = ST_S;
            end
            CMD_GETM: begin
              r.data_on_bus = 1'b1;
              ns = ST_I;
            end
            default: if (st == ST_M) r.error = ERR_UNEXPECT;
          endcase
        end
        ST_IM: begin
          if (it.cmd == CMD_DATA) begin
            r.data_to_proc = 1'b1;
            r.shared_drive = DRV_DEASSERT;
            ns = ST_M;
          end
        end
        ST_IS: begin
          if (it.cmd == CMD_DATA) begin
            r.data_to_proc = 1'b1;
            if (it.shared_in) begin
              ns = ST_S;
            end else begin
              ns = ST_E;
              r.shared_drive = DRV_DEASSERT;
            end
          end
        end
        ST_SM: begin
          if (it.cmd == CMD_GETS) begin
            r.shared_drive = DRV_ASSERT;
          end else if (it.cmd == CMD_DATA) begin
            r.data_to_proc = 1'b1;
            ns = ST_M;
          end
        end
        default: r.error = ERR_UNEXPECT;
      endcase
    end else begin
      r.error = ERR_UNEXPECT;
    end
    if (r.error != ERR_NONE) ns = st;
    if (r.data_on_bus) r.data_dest = it.requester_id;
    r.new_state = ns;
    line_tbl[idx] = ns;
    return r;
  endfunction

  task automatic push_item(input logic [2:0] cmd, input int unsigned line,
                           input int unsigned req, input bit shr,
                           input int unsigned gap, input bit drain);
    pending_t p;
    p.item.cmd = cmd;
    p.item.line_index = line[LINE_IDX_W-1:0];
    p.item.requester_id = req[NODE_W-1:0];
    p.item.shared_in = shr;
    p.gap = gap;
    p.drain = drain;
    pending_q.push_back(p);
  endtask

  // driver: present pending transactions, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin : drv
    bit fire;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      tx_wait  <= 0;
      n_in     <= 0;
    end else begin
      fire = in_valid && in_ready_o;
      if (fire) begin
        expected_q.push_back(predict_line_result(in_data));
        n_in <= n_in + 1;
      end
      if (!in_valid || fire) begin
        if (tx_wait != 0) begin
          tx_wait  <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     (!pending_q[0].drain || (!fire && n_in == n_out))) begin
          in_data  <= pending_q[0].item;
          in_valid <= 1'b1;
          tx_wait  <= pending_q[0].gap;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off  <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && !hold_off && n_in >= HOLD_AT) begin
      hold_off <= 1'b1;
      hold_cnt <= HOLD_LEN;
    end else if (hold_off) begin
      if (hold_cnt == 0) begin
        hold_off  <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : mon
    out_t        exp_r;
    string       bad;
    int unsigned w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      n_out     <= 0;
      rx_busy   <= 1'b1;
    end else begin
      if (out_valid_o && out_ready) begin
        n_out <= n_out + 1;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result %h", out_data_o));
        end else begin
          exp_r = expected_q.pop_front();
          bad = "";
          if (out_data_o.bus_request !== exp_r.bus_request) bad = {bad, " bus_request"};
          if (out_data_o.data_to_proc !== exp_r.data_to_proc) bad = {bad, " data_to_proc"};
          if (out_data_o.data_on_bus !== exp_r.data_on_bus) bad = {bad, " data_on_bus"};
          if (out_data_o.data_dest !== exp_r.data_dest) bad = {bad, " data_dest"};
          if (out_data_o.shared_drive !== exp_r.shared_drive) bad = {bad, " shared_drive"};
          if (out_data_o.miss !== exp_r.miss) bad = {bad, " miss"};
          if (out_data_o.silent_upgrade !== exp_r.silent_upgrade) bad = {bad, " silent_upgrade"};
          if (out_data_o.error !== exp_r.error) bad = {bad, " error"};
          if (out_data_o.new_state !== exp_r.new_state) bad = {bad, " new_state"};
          if (bad != "") begin
            report($sformatf("result %0d:%s got %h exp %h", n_out, bad, out_data_o, exp_r));
          end
        end
        w = rx_busy ? $urandom_range(0, 18) : 0;
        if ($urandom_range(0, 99) == 0) rx_busy <= !rx_busy;
        rx_wait   <= w;
        out_ready <= (w == 0) && !hold_off;
      end else if (rx_wait != 0) begin
        rx_wait   <= rx_wait - 1;
        out_ready <= (rx_wait == 1) && !hold_off;
      end else begin
        out_ready <= !hold_off;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stim
    int unsigned hot[8];
    int unsigned line, r, gap;
    logic [2:0]  cmd;
    bit          tx_busy, drain;
    for (int i = 0; i < LINES; i++) line_tbl[i] = ST_I;

    // line 0 through every stable state and the IS and SM transient states
    push_item(CMD_LOAD,  0, 0,  0, 0, 0);
    push_item(CMD_STORE, 0, 15, 1, 1, 0);
    push_item(CMD_GETS,  0, 15, 1, 0, 0);
    push_item(CMD_DATA,  0, 0,  0, 2, 0);
    push_item(CMD_DATA,  0, 15, 1, 0, 0);
    push_item(CMD_STORE, 0, 0,  0, 0, 0);
    push_item(CMD_DATA,  0, 15, 0, 3, 0);
    push_item(CMD_LOAD,  0, 0,  1, 0, 0);
    push_item(CMD_GETS,  0, 15, 0, 0, 0);
    push_item(CMD_GETS,  0, 0,  1, 1, 0);
    push_item(CMD_DATA,  0, 0,  0, 0, 0);
    push_item(CMD_LOAD,  0, 15, 1, 0, 0);
    push_item(CMD_STORE, 0, 0,  0, 0, 0);
    push_item(CMD_GETS,  0, 15, 1, 0, 0);
    push_item(CMD_GETM,  0, 0,  0, 4, 0);
    push_item(CMD_LOAD,  0, 15, 0, 0, 0);
    push_item(CMD_DATA,  0, 0,  1, 0, 0);
    push_item(CMD_GETM,  0, 0,  0, 0, 0);
    push_item(CMD_DATA,  0, 15, 1, 0, 0);
    // top line: shared fill, write miss, unknown commands, snoops in I
    push_item(CMD_LOAD,  LINES - 1, 15, 1, 0, 0);
    push_item(CMD_GETM,  LINES - 1, 15, 1, 0, 0);
    push_item(CMD_DATA,  LINES - 1, 0,  1, 0, 0);
    push_item(CMD_GETM,  LINES - 1, 15, 0, 0, 0);
    push_item(CMD_STORE, LINES - 1, 15, 1, 0, 0);
    push_item(CMD_DATA,  LINES - 1, 0,  1, 2, 0);
    for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++) begin
      push_item(c[2:0], LINES - 1, 15, 1, 0, 0);
    end
    push_item(CMD_GETS,  0, 15, 1, 0, 0);
    push_item(CMD_GETM,  0, 15, 1, 0, 0);

    for (int i = 0; i < 8; i++) hot[i] = $urandom_range(0, LINES - 1);
    tx_busy = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      line = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LINES - 1)
                                         : hot[$urandom_range(0, 7)];
      r = $urandom_range(0, 99);
      if (r < 20)      cmd = CMD_LOAD;
      else if (r < 35) cmd = CMD_STORE;
      else if (r < 50) cmd = CMD_GETS;
      else if (r < 62) cmd = CMD_GETM;
      else if (r < 96) cmd = CMD_DATA;
      else             cmd = 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
      if ($urandom_range(0, 149) == 0) tx_busy = !tx_busy;
      // keep offering back to back around the receiver hold-off
      if (i >= HOLD_AT - 60 && i < HOLD_AT + 80) gap = 0;
      else gap = tx_busy ? $urandom_range(0, 18) : 0;
      drain = (i == 0 || i == 700 || i == 1000);
      push_item(cmd, line, $urandom_range(0, 15), 1'($urandom_range(0, 1)), gap, drain);
    end
    total = pending_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_in != total || n_out != total) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      report($sformatf("%0d results never arrived", expected_q.size()));
    end
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- mesi_snoop_line_controller_core.f -----
rtl/mesi_lc_pkg.sv
rtl/mesi_lc_xfer.sv
rtl/mesi_snoop_line_controller_core.sv
rtl/mesi_lc_checker.sv
tb/tb.sv
